@@ design/gnpo_pkg.sv @@
// Shared constants, state type and scan tag for the nearest-point ordering block.
package gnpo_pkg;

  localparam int COORD_BITS     = 16;
  localparam int MAX_POINTS_DEF = 64;
  localparam int DIFF_BITS      = COORD_BITS + 1;
  localparam int SQ_BITS        = 2 * COORD_BITS;
  localparam int DIST_BITS      = SQ_BITS + 1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_TAKE,
    ST_SCAN,
    ST_DRAIN
  } gnpo_state_t;

  // travels alongside each scanned entry through the distance pipe
  typedef struct packed {
    logic valid;
    logic skip;
    logic fin;
  } scan_tag_t;

endpackage

@@ design/gnpo_if.sv @@
// Point input and ordered result channel interfaces.
interface gnpo_in_if import gnpo_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface

interface gnpo_out_if import gnpo_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic                         out_last;
  logic                         overflowed;

  modport source (output valid, output out_x, output out_y, output out_last,
                  output overflowed, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_last,
                  input overflowed, output ready);
endinterface

@@ design/gnpo_store.sv @@
// Point store: one write port, one read port, registered read data.
module gnpo_store import gnpo_pkg::*; #(
  parameter int DEPTH = MAX_POINTS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic signed [COORD_BITS-1:0] wx,
  input  logic signed [COORD_BITS-1:0] wy,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic signed [COORD_BITS-1:0] rx,
  output logic signed [COORD_BITS-1:0] ry
);

  logic [2*COORD_BITS-1:0] mem [DEPTH];
  logic [2*COORD_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wx, wy};
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rx = rdata_r[2*COORD_BITS-1:COORD_BITS];
  assign ry = rdata_r[COORD_BITS-1:0];

endmodule

@@ design/gnpo_dist.sv @@
// Two-stage squared-distance pipe; sum is formed combinationally at the output.
module gnpo_dist import gnpo_pkg::*; #(
  parameter int IW = $clog2(MAX_POINTS_DEF)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  scan_tag_t                    tag_i,
  input  logic [IW-1:0]                idx_i,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  output scan_tag_t                    tag_o,
  output logic [IW-1:0]                idx_o,
  output logic [DIST_BITS-1:0]         dist_o
);

  scan_tag_t                    tag1_r, tag2_r;
  logic [IW-1:0]                idx1_r, idx2_r;
  logic signed [DIFF_BITS-1:0]  dx_r, dy_r;
  logic signed [DIFF_BITS-1:0]  dx_nxt, dy_nxt;
  logic signed [2*DIFF_BITS-1:0] sqx_full, sqy_full;
  logic [SQ_BITS-1:0]           sqx_r, sqy_r;

  assign dx_nxt = $signed({px[COORD_BITS-1], px}) - $signed({cx[COORD_BITS-1], cx});
  assign dy_nxt = $signed({py[COORD_BITS-1], py}) - $signed({cy[COORD_BITS-1], cy});
  assign sqx_full = dx_r * dx_r;
  assign sqy_full = dy_r * dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= idx_i;
    idx2_r <= idx1_r;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    // squares stay below 2^SQ_BITS, upper product bits are sign copies
    sqx_r  <= sqx_full[SQ_BITS-1:0];
    sqy_r  <= sqy_full[SQ_BITS-1:0];
  end

  assign tag_o  = tag2_r;
  assign idx_o  = idx2_r;
  assign dist_o = {1'b0, sqx_r} + {1'b0, sqy_r};

endmodule

@@ design/greedy_nearest_point_ordering.sv @@
// Greedy nearest-neighbour ordering of one outline's points, set by set.
// Load: one point per cycle, ready high while loading. Emit: the first result comes
// from a store read of point 0 after the last point; each later one takes one memory
// read per stored point, the distance pipe and a re-read of the winner.
// Reset (synchronous, active low) empties the set, clears used bits and drop flag;
// store contents are left as they are and are always written before being read.
module greedy_nearest_point_ordering import gnpo_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  gnpo_in_if.sink           in_bus,
  gnpo_out_if.source        out_bus
);

  localparam int AW = $clog2(MAX_POINTS);       // store index
  localparam int CW = $clog2(MAX_POINTS + 1);   // holds the count itself

  gnpo_state_t state_r, state_nxt;

  logic [CW-1:0]                count_r;
  logic [CW-1:0]                emit_cnt_r;
  logic                         drop_r;
  logic [MAX_POINTS-1:0]        used_r;
  logic signed [COORD_BITS-1:0] cur_x_r, cur_y_r;
  logic [AW-1:0]                scan_j_r;
  logic [AW-1:0]                best_idx_r;
  logic [DIST_BITS-1:0]         best_d_r;
  logic                         found_r;
  scan_tag_t                    tag_m_r;
  logic [AW-1:0]                idx_m_r;

  logic                         out_valid_r;
  logic signed [COORD_BITS-1:0] out_x_r, out_y_r;
  logic                         out_last_r, out_ovf_r;

  // handshake and datapath controls
  logic                         in_acc;
  logic                         has_room;
  logic                         take_go;
  logic                         take_last;
  logic                         scan_fin;
  logic                         mem_we, mem_re;
  logic [AW-1:0]                mem_raddr;
  logic signed [COORD_BITS-1:0] rd_x, rd_y;
  scan_tag_t                    scan_tag;
  scan_tag_t                    tag_d;
  logic [AW-1:0]                idx_d;
  logic [DIST_BITS-1:0]         dist_d;
  logic                         better;

  assign in_acc    = in_bus.valid && in_bus.ready;
  assign has_room  = (count_r < CW'(MAX_POINTS));
  assign take_go   = !out_valid_r || out_bus.ready;
  assign take_last = ((emit_cnt_r + CW'(1)) == count_r);
  assign scan_fin  = ((CW'(scan_j_r) + CW'(1)) == count_r);
  // strict less keeps the earliest loaded point on a tie
  assign better    = tag_d.valid && !tag_d.skip && (!found_r || (dist_d < best_d_r));

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc && in_bus.last_point) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_TAKE;
      end
      ST_TAKE: begin
        if (take_go) state_nxt = take_last ? ST_LOAD : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_fin) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        // last scanned entry reaches the compare stage
        if (tag_d.valid && tag_d.fin) state_nxt = ST_READ;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // ---------------- outputs of the state machine ----------------
  always_comb begin
    in_bus.ready = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = best_idx_r;
    scan_tag     = '0;
    unique case (state_r)
      ST_LOAD: begin
        in_bus.ready = 1'b1;
        mem_we       = in_acc && has_room;
      end
      ST_READ: begin
        mem_re    = 1'b1;
        mem_raddr = best_idx_r;
      end
      ST_SCAN: begin
        mem_re         = 1'b1;
        mem_raddr      = scan_j_r;
        scan_tag.valid = 1'b1;
        scan_tag.skip  = used_r[scan_j_r];
        scan_tag.fin   = scan_fin;
      end
      ST_TAKE, ST_DRAIN: begin
      end
      default: begin
      end
    endcase
  end

  // ---------------- point store ----------------
  gnpo_store #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[AW-1:0]),
    .wx    (in_bus.point_x),
    .wy    (in_bus.point_y),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rx    (rd_x),
    .ry    (rd_y)
  );

  // tag lines up with the registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_m_r <= '0;
    end else begin
      tag_m_r <= scan_tag;
    end
  end

  always_ff @(posedge clk) begin
    idx_m_r <= scan_j_r;
  end

  // ---------------- distance pipe ----------------
  gnpo_dist #(
    .IW (AW)
  ) u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_i  (tag_m_r),
    .idx_i  (idx_m_r),
    .px     (rd_x),
    .py     (rd_y),
    .cx     (cur_x_r),
    .cy     (cur_y_r),
    .tag_o  (tag_d),
    .idx_o  (idx_d),
    .dist_o (dist_d)
  );

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      count_r    <= '0;
      emit_cnt_r <= '0;
      drop_r     <= 1'b0;
      used_r     <= '0;
      scan_j_r   <= '0;
      best_idx_r <= '0;
      found_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == ST_LOAD && in_acc) begin
        if (has_room) count_r <= count_r + CW'(1);
        else          drop_r  <= 1'b1;
        // the first point of the set is always emitted first
        best_idx_r <= '0;
      end

      if (state_r == ST_TAKE && take_go) begin
        scan_j_r <= '0;
        found_r  <= 1'b0;
        if (take_last) begin
          count_r    <= '0;
          emit_cnt_r <= '0;
          drop_r     <= 1'b0;
          used_r     <= '0;
        end else begin
          emit_cnt_r         <= emit_cnt_r + CW'(1);
          used_r[best_idx_r] <= 1'b1;
        end
      end

      if (state_r == ST_SCAN) begin
        scan_j_r <= scan_j_r + AW'(1);
      end

      if (better) begin
        found_r    <= 1'b1;
        best_idx_r <= idx_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      best_d_r <= dist_d;
    end
    if (state_r == ST_TAKE && take_go) begin
      cur_x_r <= rd_x;
      cur_y_r <= rd_y;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_TAKE && take_go) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_TAKE && take_go) begin
      out_x_r    <= rd_x;
      out_y_r    <= rd_y;
      out_last_r <= take_last;
      out_ovf_r  <= drop_r;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.out_x      = out_x_r;
  assign out_bus.out_y      = out_y_r;
  assign out_bus.out_last   = out_last_r;
  assign out_bus.overflowed = out_ovf_r;

endmodule
